>>> rtl/core/pcws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcws_pkg: shared types and constants of the per-channel smoothing block
// Field widths of the transfers, the divisor width and the sequencer states.
// ----------------------------------------------------------------------------
package pcws_pkg;

    // Field widths of the input and result transfers.
    localparam int CHANNEL_W = 8;
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 8;

    // The divisor is weight + 1, which needs one bit more than the weight.
    localparam int DIVISOR_W = WEIGHT_W + 1;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/pcws_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcws_store: per-channel average memory
// One write port and one registered read port. Per-entry valid bits make
// every entry read as zero until it has been written once after reset.
// ----------------------------------------------------------------------------
module pcws_store #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 24,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;

    // Memory array write; the array itself carries no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; an entry never written reads as zero.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    // Valid bits are cleared by reset and set by the first write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/pcws_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcws_divider: radix-2 restoring divider
// Produces one quotient bit per cycle. The upper numerator bits must already
// be smaller than the divisor, so only QUO_W steps are needed.
// ----------------------------------------------------------------------------
module pcws_divider #(
    parameter int QUO_W = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [QUO_W+pcws_pkg::DIVISOR_W-1:0] numerator,
    input  logic [pcws_pkg::DIVISOR_W-1:0] divisor,
    output logic                           done,
    output logic [QUO_W-1:0]               quotient
);

    localparam int DW    = pcws_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]    div_reg, div_next;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fits;

    // One shift-subtract step on the partial remainder.
    always_comb
    begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Step control: load on start, iterate while busy.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = numerator[QUO_W+DW-1:QUO_W];
            quo_next  = numerator[QUO_W-1:0];
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/per_channel_weighted_smoothing.sv
`timescale 1ns / 1ps
// An in-range item runs through the states MUL, LOAD, DIV, WRITE and DONE before
// its result is loaded; an out-of-range channel goes straight to DONE and its
// sample is passed through unchanged. A new item is taken only once the
// sequencer is back in IDLE, after the previous result was loaded for output.
// Reset clears the sequencer, the output valid flag and all per-channel valid
// bits, so every average reads as zero after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
// per_channel_weighted_smoothing: per-channel exponential moving average
// Keeps one fixed-point average per channel and updates it with
// (old * weight + sample) / (weight + 1) through a shared divider.
// ----------------------------------------------------------------------------
module per_channel_weighted_smoothing #(
    parameter int NUM_CHANNELS = 32,
    parameter int FRAC_BITS    = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pcws_pkg::CHANNEL_W-1:0] channel,
    input  logic [pcws_pkg::SAMPLE_W-1:0]  sample,
    input  logic [pcws_pkg::WEIGHT_W-1:0]  weight,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pcws_pkg::SAMPLE_W-1:0]  smoothed
);

    localparam int SW     = pcws_pkg::SAMPLE_W + FRAC_BITS;
    localparam int NW     = SW + pcws_pkg::DIVISOR_W;
    localparam int PW     = SW + pcws_pkg::WEIGHT_W;
    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    pcws_pkg::state_t state_reg, state_next;

    logic                           in_xfer;
    logic                           in_range;
    logic                           out_free;
    logic                           rd_en;
    logic                           div_start;
    logic                           wr_en;
    logic                           load_out;
    logic                           div_done;
    logic [SW-1:0]                  rd_data;
    logic [SW-1:0]                  quotient;
    logic [PW-1:0]                  product;

    logic [ADDR_W-1:0]              addr_reg;
    logic [pcws_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [pcws_pkg::WEIGHT_W-1:0]  weight_reg;
    logic [NW-1:0]                  num_reg;
    logic [pcws_pkg::SAMPLE_W-1:0]  result_reg;
    logic                           out_valid_reg;
    logic [pcws_pkg::SAMPLE_W-1:0]  smoothed_reg;

    // Input transfer and range check.
    assign in_xfer  = in_valid && !in_stall;
    assign in_range = ({1'b0, channel} < 9'(NUM_CHANNELS));
    assign out_free = !out_valid_reg || !out_stall;
    assign product  = PW'(rd_data) * PW'(weight_reg);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcws_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = in_range ? pcws_pkg::ST_MUL : pcws_pkg::ST_DONE;
                end
            end
            pcws_pkg::ST_MUL:   state_next = pcws_pkg::ST_LOAD;
            pcws_pkg::ST_LOAD:  state_next = pcws_pkg::ST_DIV;
            pcws_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = pcws_pkg::ST_WRITE;
                end
            end
            pcws_pkg::ST_WRITE: state_next = pcws_pkg::ST_DONE;
            pcws_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = pcws_pkg::ST_IDLE;
                end
            end
            default:            state_next = pcws_pkg::ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        in_stall  = 1'b1;
        rd_en     = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            pcws_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                rd_en    = in_valid && in_range;
            end
            pcws_pkg::ST_LOAD:  div_start = 1'b1;
            pcws_pkg::ST_WRITE: wr_en     = 1'b1;
            pcws_pkg::ST_DONE:  load_out  = out_free;
            default:            in_stall  = 1'b1;
        endcase
    end

    // Sequencer state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcws_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture, numerator build and result capture.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            addr_reg   <= channel[ADDR_W-1:0];
            sample_reg <= sample;
            weight_reg <= weight;
            result_reg <= sample;
        end
        if (state_reg == pcws_pkg::ST_MUL)
        begin
            num_reg <= NW'(product) + (NW'(sample_reg) << FRAC_BITS);
        end
        if (wr_en)
        begin
            result_reg <= quotient[SW-1:FRAC_BITS];
        end
        if (load_out)
        begin
            smoothed_reg <= result_reg;
        end
    end

    // Per-channel average memory.
    pcws_store #(
        .DEPTH  (NUM_CHANNELS),
        .DATA_W (SW),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (channel[ADDR_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (quotient)
    );

    // Shared divider for the weighted average.
    pcws_divider #(
        .QUO_W (SW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (num_reg),
        .divisor   ({1'b0, weight_reg} + 9'd1),
        .done      (div_done),
        .quotient  (quotient)
    );

    assign out_valid = out_valid_reg;
    assign smoothed  = smoothed_reg;

endmodule

>>> tb/smoothing_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothing_checker: scoreboard for the per-channel smoothing block
// Watches both channels. It keeps its own per-channel fixed-point averages to
// predict each smoothed value, and compares every output transfer with the
// oldest prediction.
// ----------------------------------------------------------------------------
module smoothing_checker #(
    parameter int NUM_CHANNELS = 32,
    parameter int FRAC_BITS    = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [pcws_pkg::CHANNEL_W-1:0] channel,
    input  logic [pcws_pkg::SAMPLE_W-1:0]  sample,
    input  logic [pcws_pkg::WEIGHT_W-1:0]  weight,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [pcws_pkg::SAMPLE_W-1:0]  smoothed,
    input  logic                           end_check,
    output int                             pending,
    output int                             fail_count
);

    localparam int AVG_W = pcws_pkg::SAMPLE_W + FRAC_BITS;
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [AVG_W-1:0]              average_mem [NUM_CHANNELS];
    logic [pcws_pkg::SAMPLE_W-1:0] expected_smoothed [$];
    logic                          leftover_checked;

    initial
    begin
        pending          = 0;
        fail_count       = 0;
        leftover_checked = 1'b0;
    end

    // Prints one line per failure and counts it.
    task automatic report_failure(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // New average: (old * weight + sample in fixed point) / (weight + 1), truncated.
    function automatic logic [AVG_W-1:0] next_average(
        input logic [AVG_W-1:0]              old_avg,
        input logic [pcws_pkg::SAMPLE_W-1:0] raw,
        input logic [pcws_pkg::WEIGHT_W-1:0] w
    );
        logic [63:0] num;
        num = 64'(old_avg) * 64'(w) + (64'(raw) << FRAC_BITS);
        return AVG_W'(num / (64'(w) + 64'd1));
    endfunction

    // Predict on every input transfer, compare on every output transfer.
    always @(posedge clk or negedge rst_n)
    begin
        logic [AVG_W-1:0]              new_avg;
        logic [pcws_pkg::SAMPLE_W-1:0] predicted;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                average_mem[i] = '0;
            expected_smoothed.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (int'(channel) < NUM_CHANNELS)
                begin
                    new_avg = next_average(average_mem[channel[IDX_W-1:0]], sample, weight);
                    average_mem[channel[IDX_W-1:0]] = new_avg;
                    expected_smoothed.push_back(pcws_pkg::SAMPLE_W'(new_avg >> FRAC_BITS));
                end
                else
                begin
                    // Out-of-range channels pass the sample straight through.
                    expected_smoothed.push_back(sample);
                end
            end

            if (out_valid && !out_stall)
            begin
                if (expected_smoothed.size() == 0)
                    report_failure($sformatf("unexpected result smoothed=%h", smoothed));
                else
                begin
                    predicted = expected_smoothed.pop_front();
                    if (smoothed !== predicted)
                        report_failure($sformatf("smoothed got %h, predicted %h",
                                                 smoothed, predicted));
                end
            end

            // At the end of the run, results still owed count as one failure.
            if (end_check && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (expected_smoothed.size() != 0)
                    report_failure($sformatf("%0d predicted results never arrived",
                                             expected_smoothed.size()));
            end

            pending <= expected_smoothed.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the per-channel smoothing block
// Sends a directed set of edge cases followed by random samples with random
// idle cycles on both sides, a long output hold-off and a full drain pause.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_CHANNELS   = 32;
    localparam int FRAC_BITS      = 8;
    localparam int RANDOM_ITEMS   = 1630;
    localparam int PAUSE_AT_ITEM  = 400;
    localparam int QUIET_FIRST    = 700;
    localparam int QUIET_LAST     = 1000;
    localparam int HOLD_START     = 6000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RX_QUIET_FIRST = 22000;
    localparam int RX_QUIET_LAST  = 32000;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic [pcws_pkg::CHANNEL_W-1:0] channel   = '0;
    logic [pcws_pkg::SAMPLE_W-1:0]  sample    = '0;
    logic [pcws_pkg::WEIGHT_W-1:0]  weight    = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [pcws_pkg::SAMPLE_W-1:0]  smoothed;
    logic                           end_check = 1'b0;
    int                             pending;
    int                             fail_count;
    int                             items_sent  = 0;
    int                             rx_cycle    = 0;
    int                             hold_left   = 0;
    int                             idle_cycles = 0;

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    per_channel_weighted_smoothing #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .channel  (channel),
        .sample   (sample),
        .weight   (weight),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .smoothed (smoothed)
    );

    smoothing_checker #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .FRAC_BITS   (FRAC_BITS)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .channel   (channel),
        .sample    (sample),
        .weight    (weight),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .smoothed  (smoothed),
        .end_check (end_check),
        .pending   (pending),
        .fail_count(fail_count)
    );

    // Offers one item, waits for its transfer, then sometimes drops in_valid for a random gap.
    task automatic send_item(
        input logic [pcws_pkg::CHANNEL_W-1:0] ch,
        input logic [pcws_pkg::SAMPLE_W-1:0]  raw,
        input logic [pcws_pkg::WEIGHT_W-1:0]  w
    );
        int gap;
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= raw;
        weight   <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (!(items_sent >= QUIET_FIRST && items_sent < QUIET_LAST)
            && $urandom_range(0, 99) < 10)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering items until every predicted result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Receiver: random stalls, one long hold-off and a stretch with none.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (rx_cycle == HOLD_START)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
        end
        else if (rx_cycle >= RX_QUIET_FIRST && rx_cycle < RX_QUIET_LAST)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 10);
    end

    // Counts cycles in which neither channel makes a transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        int                             sel;
        logic [pcws_pkg::CHANNEL_W-1:0] ch;
        logic [pcws_pkg::SAMPLE_W-1:0]  raw;
        logic [pcws_pkg::WEIGHT_W-1:0]  w;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, zero weight, out-of-range channels and truncation.
        send_item(8'd0,   16'h0000, 8'd0);
        send_item(8'd0,   16'hFFFF, 8'd0);
        send_item(8'd0,   16'h0000, 8'd255);
        send_item(8'd0,   16'hFFFF, 8'd255);
        send_item(8'd31,  16'hFFFF, 8'd255);
        send_item(8'd31,  16'hFFFF, 8'd1);
        send_item(8'd31,  16'h0000, 8'd0);
        send_item(8'd32,  16'h1234, 8'd9);
        send_item(8'd255, 16'hFFFF, 8'd255);
        send_item(8'd255, 16'h0000, 8'd0);
        send_item(8'd1,   16'h0001, 8'd2);
        send_item(8'd1,   16'h0001, 8'd2);
        send_item(8'd1,   16'h0002, 8'd3);
        send_item(8'd2,   16'hAAAA, 8'd1);
        send_item(8'd2,   16'h5555, 8'd1);
        send_item(8'd3,   16'h8000, 8'd128);
        send_item(8'd3,   16'h7FFF, 8'd127);
        send_item(8'd30,  16'hFFFF, 8'd254);
        send_item(8'd33,  16'h0000, 8'd255);
        send_item(8'd0,   16'h0001, 8'd255);

        // Random part. A small group of channels gets a large share of the traffic so
        // that averages build up over long runs of updates.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (items_sent == PAUSE_AT_ITEM)
                drain_results();

            sel = $urandom_range(0, 99);
            if (sel < 40)
                ch = pcws_pkg::CHANNEL_W'($urandom_range(0, 3));
            else if (sel < 80)
                ch = pcws_pkg::CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1));
            else if (sel < 90)
                ch = pcws_pkg::CHANNEL_W'($urandom_range(NUM_CHANNELS, 255));
            else
            begin
                case ($urandom_range(0, 3))
                    0:       ch = pcws_pkg::CHANNEL_W'(0);
                    1:       ch = pcws_pkg::CHANNEL_W'(NUM_CHANNELS - 1);
                    2:       ch = pcws_pkg::CHANNEL_W'(NUM_CHANNELS);
                    default: ch = pcws_pkg::CHANNEL_W'(255);
                endcase
            end

            sel = $urandom_range(0, 99);
            if (sel < 15)
                w = '0;
            else if (sel < 30)
                w = '1;
            else
                w = pcws_pkg::WEIGHT_W'($urandom_range(0, 255));

            sel = $urandom_range(0, 99);
            if (sel < 10)
                raw = '0;
            else if (sel < 20)
                raw = '1;
            else
                raw = pcws_pkg::SAMPLE_W'($urandom_range(0, 65535));

            send_item(ch, raw, w);
        end

        // Let every result come out, then allow for the block's latency.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/pcws_pkg.sv
rtl/core/pcws_store.sv
rtl/core/pcws_divider.sv
rtl/core/per_channel_weighted_smoothing.sv
tb/smoothing_checker.sv
tb/testbench.sv
